// ===== hdl/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective repeat receiver: field widths,
// slot store word layout, result codes and the sequencer states.
// ----------------------------------------------------------------------------
package srr_pkg;

   localparam int unsigned SEQ_W                = 16;
   localparam int unsigned CHECK_W              = 32;
   localparam int unsigned WORD_W               = 64;
   localparam int unsigned HIGH_W               = 32;
   localparam int unsigned PAYLOAD_BYTES        = 20;
   localparam int unsigned BUFFER_SLOTS_DEFAULT = 32;

   // slot word holds low, mid and high payload words
   localparam int unsigned SLOT_DATA_W = 2 * WORD_W + HIGH_W;

   // signed sum of up to twenty bytes fits in this many bits
   localparam int unsigned BYTE_SUM_W = 13;

   // reciprocal used for the seq modulo slot count
   localparam int unsigned RECIP_SHIFT = 22;
   localparam int unsigned RECIP_W     = 22;

   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_WRITE,
      ST_WALK_READ,
      ST_WALK_OUT,
      ST_ACK
   } srr_state_type;

endpackage

// ===== hdl/srr_req_if.sv =====
// ----------------------------------------------------------------------------
// srr_req_if
// Request channel: one arriving data packet per transfer.
// ----------------------------------------------------------------------------
interface srr_req_if;
   import srr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SEQ_W-1:0]          seq_num;
   logic [SEQ_W-1:0]          ack_num;
   logic signed [CHECK_W-1:0] check_value;
   logic [WORD_W-1:0]         payload_low;
   logic [WORD_W-1:0]         payload_mid;
   logic [HIGH_W-1:0]         payload_high;

   modport source (
      output valid, seq_num, ack_num, check_value,
             payload_low, payload_mid, payload_high,
      input  ready
   );

   modport sink (
      input  valid, seq_num, ack_num, check_value,
             payload_low, payload_mid, payload_high,
      output ready
   );

endinterface

// ===== hdl/srr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// srr_rsp_if
// Response channel: delivered messages and acknowledgments.
// ----------------------------------------------------------------------------
interface srr_rsp_if;
   import srr_pkg::*;

   logic              valid;
   logic              ready;
   logic              result_kind;
   logic [WORD_W-1:0] out_payload_low;
   logic [WORD_W-1:0] out_payload_mid;
   logic [HIGH_W-1:0] out_payload_high;
   logic [SEQ_W-1:0]  ack_number;
   logic [SEQ_W-1:0]  ack_check;
   logic              last_of_run;

   modport source (
      output valid, result_kind, out_payload_low, out_payload_mid,
             out_payload_high, ack_number, ack_check, last_of_run,
      input  ready
   );

   modport sink (
      input  valid, result_kind, out_payload_low, out_payload_mid,
             out_payload_high, ack_number, ack_check, last_of_run,
      output ready
   );

endinterface

// ===== hdl/selective_repeat_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit
// Selective repeat receiver: checks, buffers and delivers packets in order.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one data packet per request (seq, ack, checksum and a
//   20 byte payload). rsp_if returns, for each good packet, the in-order
//   messages it releases (kind deliver) followed by one acknowledgment
//   (kind ack, last_of_run set). A packet with a bad checksum yields nothing.
//   Sequence: a request is taken in idle, then the sum state adds the bytes
//   and the check state compares the checksum, the write state writes the
//   slot, each delivered message passes a slot read state and then a load
//   into the output register, and the ack state loads the acknowledgment.
//   Each delivered message takes one slot memory read.
//   A new request is taken while the ack of the previous one still waits in
//   the output register. When rsp_if.ready is low the message load and ack
//   states hold in place until the output register frees up.
//   Reset clears all slot valid bits and both sequence counters at once; the
//   payload memory needs no clearing since a slot is read only when valid.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_unit #(
   parameter int unsigned BUFFER_SLOTS = srr_pkg::BUFFER_SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   srr_req_if.sink   req_if,
   srr_rsp_if.source rsp_if
);
   import srr_pkg::*;

   localparam int unsigned SlotW = $clog2(BUFFER_SLOTS);
   localparam int unsigned CntW  = $clog2(BUFFER_SLOTS + 1);
   localparam logic [RECIP_W-1:0] RecipMul =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(BUFFER_SLOTS) - 64'd1) / 64'(BUFFER_SLOTS));
   localparam logic [SEQ_W-1:0] SlotsSeq = SEQ_W'(BUFFER_SLOTS);
   localparam logic [SlotW-1:0] LastSlot = SlotW'(BUFFER_SLOTS - 1);
   localparam logic [CntW-1:0]  SlotsCnt = CntW'(BUFFER_SLOTS);

   srr_state_type state_ff, state_in;

   // captured request
   logic [SEQ_W-1:0]          seq_ff;
   logic [SEQ_W-1:0]          ack_ff;
   logic signed [CHECK_W-1:0] check_ff;
   logic [WORD_W-1:0]         plo_ff, pmid_ff;
   logic [HIGH_W-1:0]         phi_ff;

   // checksum and slot index pipeline
   logic [BYTE_SUM_W-1:0] sum_lo_ff, sum_lo_in;
   logic [BYTE_SUM_W-1:0] sum_mid_ff, sum_mid_in;
   logic [BYTE_SUM_W-1:0] sum_hi_ff, sum_hi_in;
   logic [SEQ_W:0]        seqack_ff, seqack_in;
   logic [SEQ_W-1:0]      quot_ff, quot_in;
   logic [SlotW-1:0]      slot_ff, slot_in;

   logic [SEQ_W+RECIP_W-1:0] recip_prod;
   logic [SEQ_W-1:0]         rem_raw, rem_fix;
   logic [BYTE_SUM_W-1:0]    byte_total;
   logic [CHECK_W-1:0]       full_sum;
   logic                     csum_ok;

   // receive window state
   logic [BUFFER_SLOTS-1:0] valid_ff, valid_in;
   logic [SEQ_W-1:0]        expected_ff, expected_in;
   logic [SlotW-1:0]        exp_slot_ff, exp_slot_in;
   logic [SEQ_W-1:0]        highest_ff, highest_in;
   logic [CntW-1:0]         span_ff, span_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic [SEQ_W-1:0]        span_diff;
   logic [SEQ_W:0]          span_full;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [WORD_W-1:0] rsp_lo_ff, rsp_lo_in;
   logic [WORD_W-1:0] rsp_mid_ff, rsp_mid_in;
   logic [HIGH_W-1:0] rsp_hi_ff, rsp_hi_in;
   logic [SEQ_W-1:0]  rsp_num_ff, rsp_num_in;
   logic [SEQ_W-1:0]  rsp_chk_ff, rsp_chk_in;
   logic              rsp_last_ff, rsp_last_in;

   // control
   logic req_accept;
   logic out_free;
   logic walk_go;
   logic ram_wr_en;
   logic ram_rd_en;
   logic load_deliver;
   logic load_ack;

   logic [SLOT_DATA_W-1:0] ram_rd_data;

   srr_slot_ram #(
      .DEPTH (BUFFER_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data ({phi_ff, pmid_ff, plo_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (exp_slot_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign walk_go    = (cnt_ff < span_ff) && valid_ff[exp_slot_ff];
   assign req_accept = req_if.valid && req_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = csum_ok ? ST_WRITE : ST_IDLE;
         end
         ST_WRITE: begin
            state_in = (seq_ff == expected_ff) ? ST_WALK_READ : ST_ACK;
         end
         ST_WALK_READ: begin
            state_in = walk_go ? ST_WALK_OUT : ST_ACK;
         end
         ST_WALK_OUT: begin
            if (out_free) begin
               state_in = ST_WALK_READ;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      load_deliver = 1'b0;
      load_ack     = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_if.ready = 1'b1;
         ST_WRITE:     ram_wr_en    = 1'b1;
         ST_WALK_READ: ram_rd_en    = walk_go;
         ST_WALK_OUT:  load_deliver = out_free;
         ST_ACK:       load_ack     = out_free;
         default:      ;
      endcase
   end

   // byte sums and reciprocal multiply
   always_comb begin
      sum_lo_in  = '0;
      sum_mid_in = '0;
      sum_hi_in  = '0;
      for (int k = 0; k < 8; k++) begin
         sum_lo_in  = sum_lo_in  + {{(BYTE_SUM_W-8){plo_ff[8*k+7]}},  plo_ff[8*k +: 8]};
         sum_mid_in = sum_mid_in + {{(BYTE_SUM_W-8){pmid_ff[8*k+7]}}, pmid_ff[8*k +: 8]};
      end
      for (int k = 0; k < int'(PAYLOAD_BYTES) - 16; k++) begin
         sum_hi_in = sum_hi_in + {{(BYTE_SUM_W-8){phi_ff[8*k+7]}}, phi_ff[8*k +: 8]};
      end
      seqack_in  = {1'b0, seq_ff} + {1'b0, ack_ff};
      recip_prod = (SEQ_W+RECIP_W)'(seq_ff) * (SEQ_W+RECIP_W)'(RecipMul);
      quot_in    = recip_prod[SEQ_W+RECIP_SHIFT-1:RECIP_SHIFT];
   end

   // checksum compare and slot index
   always_comb begin
      byte_total = sum_lo_ff + sum_mid_ff + sum_hi_ff;
      full_sum   = {{(CHECK_W-BYTE_SUM_W){byte_total[BYTE_SUM_W-1]}}, byte_total}
                 + CHECK_W'(seqack_ff);
      csum_ok    = full_sum == $unsigned(check_ff);
      rem_raw    = seq_ff - SEQ_W'(quot_ff * SlotsSeq);
      rem_fix    = (rem_raw >= SlotsSeq) ? rem_raw - SlotsSeq : rem_raw;
      slot_in    = rem_fix[SlotW-1:0];
   end

   // window bookkeeping
   always_comb begin
      valid_in    = valid_ff;
      expected_in = expected_ff;
      exp_slot_in = exp_slot_ff;
      highest_in  = highest_ff;
      span_in     = span_ff;
      cnt_in      = cnt_ff;
      span_diff   = '0;
      span_full   = '0;
      if (state_ff == ST_WRITE) begin
         valid_in[slot_ff] = 1'b1;
         highest_in = (seq_ff >= highest_ff) ? seq_ff : highest_ff;
         // walk covers at most highest - expected + 1 numbers, capped by ring size
         span_diff = highest_in - seq_ff;
         span_full = {1'b0, span_diff} + (SEQ_W+1)'(1);
         span_in   = (span_full > (SEQ_W+1)'(BUFFER_SLOTS)) ? SlotsCnt
                                                            : span_full[CntW-1:0];
         cnt_in    = '0;
      end
      if (ram_rd_en) begin
         valid_in[exp_slot_ff] = 1'b0;
         expected_in = expected_ff + SEQ_W'(1);
         // slot index restarts with the sequence number when it wraps
         exp_slot_in = (exp_slot_ff == LastSlot || expected_ff == '1) ? '0
                                                                      : exp_slot_ff + SlotW'(1);
         cnt_in      = cnt_ff + CntW'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_mid_in   = rsp_mid_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_chk_in   = rsp_chk_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (load_deliver) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_DELIVER;
         rsp_lo_in    = ram_rd_data[WORD_W-1:0];
         rsp_mid_in   = ram_rd_data[2*WORD_W-1:WORD_W];
         rsp_hi_in    = ram_rd_data[SLOT_DATA_W-1:2*WORD_W];
         rsp_num_in   = '0;
         rsp_chk_in   = '0;
         rsp_last_in  = 1'b0;
      end else if (load_ack) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_ACK;
         rsp_lo_in    = '0;
         rsp_mid_in   = '0;
         rsp_hi_in    = '0;
         rsp_num_in   = seq_ff;
         rsp_chk_in   = seq_ff;
         rsp_last_in  = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         expected_ff  <= '0;
         exp_slot_ff  <= '0;
         highest_ff   <= '0;
         span_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         expected_ff  <= expected_in;
         exp_slot_ff  <= exp_slot_in;
         highest_ff   <= highest_in;
         span_ff      <= span_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         seq_ff   <= req_if.seq_num;
         ack_ff   <= req_if.ack_num;
         check_ff <= req_if.check_value;
         plo_ff   <= req_if.payload_low;
         pmid_ff  <= req_if.payload_mid;
         phi_ff   <= req_if.payload_high;
      end
      if (state_ff == ST_SUM) begin
         sum_lo_ff  <= sum_lo_in;
         sum_mid_ff <= sum_mid_in;
         sum_hi_ff  <= sum_hi_in;
         seqack_ff  <= seqack_in;
         quot_ff    <= quot_in;
      end
      if (state_ff == ST_CHECK) begin
         slot_ff <= slot_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_lo_ff   <= rsp_lo_in;
      rsp_mid_ff  <= rsp_mid_in;
      rsp_hi_ff   <= rsp_hi_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_chk_ff  <= rsp_chk_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.result_kind      = rsp_kind_ff;
   assign rsp_if.out_payload_low  = rsp_lo_ff;
   assign rsp_if.out_payload_mid  = rsp_mid_ff;
   assign rsp_if.out_payload_high = rsp_hi_ff;
   assign rsp_if.ack_number       = rsp_num_ff;
   assign rsp_if.ack_check        = rsp_chk_ff;
   assign rsp_if.last_of_run      = rsp_last_ff;

endmodule

// ===== hdl/srr_slot_ram.sv =====
// ----------------------------------------------------------------------------
// srr_slot_ram
// Payload store of the receive ring: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module srr_slot_ram #(
   parameter int unsigned DEPTH = srr_pkg::BUFFER_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [srr_pkg::SLOT_DATA_W-1:0] wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [srr_pkg::SLOT_DATA_W-1:0] rd_data
);
   import srr_pkg::*;

   logic [SLOT_DATA_W-1:0] mem [DEPTH];
   logic [SLOT_DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the selective repeat receiver. A directed table
// covers checksum extremes, a true zero checksum, corrupt packets, out of
// order arrival, duplicates and slot aliasing. Randomized traffic follows,
// mostly shuffled in-window bursts with noise, under several idle patterns
// and one long response hold-off. Every response is compared field by field
// against a behavioral model of the receive window kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;
   import srr_pkg::*;

   localparam int unsigned SLOTS        = BUFFER_SLOTS_DEFAULT;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PRINT_LIMIT  = 40;
   localparam int unsigned N_ROWS       = 17;

   typedef enum logic [1:0] {
      OUT_PREDICT,
      OUT_NONE,
      OUT_ACK,
      OUT_SELF_ACK
   } outcome_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [SEQ_W-1:0]   ack;
      logic [CHECK_W-1:0] check;
      logic [WORD_W-1:0]  low;
      logic [WORD_W-1:0]  mid;
      logic [HIGH_W-1:0]  high;
   } packet_type;

   typedef struct packed {
      logic               kind;
      logic [WORD_W-1:0]  low;
      logic [WORD_W-1:0]  mid;
      logic [HIGH_W-1:0]  high;
      logic [SEQ_W-1:0]   num;
      logic [SEQ_W-1:0]   chk;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [SEQ_W-1:0]   ack;
      logic [CHECK_W-1:0] check;
      logic [WORD_W-1:0]  low;
      logic [WORD_W-1:0]  mid;
      logic [HIGH_W-1:0]  high;
      logic               fix_check;
      outcome_type        outcome;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   srr_req_if req ();
   srr_rsp_if rsp ();

   selective_repeat_receiver_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   always #2 clock = ~clock;

   // receive window model
   logic [WORD_W-1:0] win_low  [SLOTS];
   logic [WORD_W-1:0] win_mid  [SLOTS];
   logic [HIGH_W-1:0] win_high [SLOTS];
   logic              win_full [SLOTS];
   logic [SEQ_W-1:0]  next_seq = '0;
   logic [SEQ_W-1:0]  top_seq  = '0;
   result_type        due_results [$];

   int mismatches    = 0;
   int sent          = 0;
   int hold_asked    = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   // fix_check rows get their checksum computed, the others carry it as typed
   dir_row_type dir_rows [N_ROWS] = '{
      '{16'd0, 16'd0, 32'd0, 64'd0, 64'd0, 32'd0, 1'b1, OUT_SELF_ACK},
      // true zero checksum on a good packet
      '{16'd1, 16'd0, 32'd0, 64'h0000_0000_0000_00FF, 64'd0, 32'd0, 1'b0, OUT_SELF_ACK},
      '{16'd2, 16'd0, 32'd1, 64'd0, 64'd0, 32'd0, 1'b0, OUT_NONE},
      '{16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, '1, '1, '1, 1'b0, OUT_NONE},
      '{16'h8000, 16'h8000, 32'h8000_0000, {8{8'h80}}, {8{8'h80}}, {4{8'h80}},
        1'b0, OUT_NONE},
      '{16'd2, 16'hFFFF, 32'd0, '1, '1, '1, 1'b1, OUT_SELF_ACK},
      // most negative payload sum
      '{16'd3, 16'd0, 32'd0, {8{8'h80}}, {8{8'h80}}, {4{8'h80}}, 1'b1, OUT_SELF_ACK},
      '{16'd4, 16'h1234, 32'd0, {8{8'h7F}}, {8{8'h7F}}, {4{8'h7F}}, 1'b1, OUT_SELF_ACK},
      // out of order, then the gap filler releases three
      '{16'd7, 16'd1, 32'd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        32'hDEAD_BEEF, 1'b1, OUT_ACK},
      '{16'd6, 16'd2, 32'd0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        32'h5A5A_5A5A, 1'b1, OUT_ACK},
      '{16'd5, 16'd3, 32'd0, 64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0,
        32'h1357_9BDF, 1'b1, OUT_PREDICT},
      // duplicate and stale packets behind the window
      '{16'd5, 16'd3, 32'd0, 64'h0F1E_2D3C_4B5A_6978, 64'h8796_A5B4_C3D2_E1F0,
        32'h1357_9BDF, 1'b1, OUT_ACK},
      '{16'd3, 16'd0, 32'd0, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888,
        32'h9999_AAAA, 1'b1, OUT_ACK},
      // aliases slot of seq 8, then seq 8 overwrites it
      '{16'd40, 16'h0BAD, 32'd0, 64'hC0C1_C2C3_C4C5_C6C7, 64'hD0D1_D2D3_D4D5_D6D7,
        32'hE0E1_E2E3, 1'b1, OUT_ACK},
      '{16'd8, 16'd0, 32'd0, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
        32'h0F0F_F0F0, 1'b1, OUT_SELF_ACK},
      '{16'd9, 16'd0, 32'hFFFF_FFFF, 64'd0, 64'd0, 32'd0, 1'b0, OUT_NONE},
      '{16'd9, 16'h7FFF, 32'd0, 64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000,
        32'h8001_0080, 1'b1, OUT_SELF_ACK}
   };

   function automatic logic [CHECK_W-1:0] packet_sum(packet_type p);
      logic [CHECK_W-1:0] s;
      logic [8*PAYLOAD_BYTES-1:0] bytes;
      logic [7:0] b;
      bytes = {p.high, p.mid, p.low};
      s = CHECK_W'(p.seq) + CHECK_W'(p.ack);
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         b = bytes[8*k +: 8];
         s = s + {{24{b[7]}}, b};
      end
      return s;
   endfunction

   // updates the window and queues the responses the packet releases
   function automatic void receive_packet(packet_type p, bit record);
      int unsigned slot;
      int unsigned span;
      int unsigned walked;
      logic [SEQ_W-1:0] gap;
      result_type r;
      if (packet_sum(p) != p.check) return;
      slot = p.seq % SLOTS;
      win_low[slot]  = p.low;
      win_mid[slot]  = p.mid;
      win_high[slot] = p.high;
      win_full[slot] = 1'b1;
      if (p.seq >= top_seq) top_seq = p.seq;
      if (p.seq == next_seq) begin
         gap = top_seq - next_seq;
         span = gap + 1;
         if (span > SLOTS) span = SLOTS;
         walked = 0;
         while (walked < span && win_full[next_seq % SLOTS]) begin
            slot = next_seq % SLOTS;
            r = '{KIND_DELIVER, win_low[slot], win_mid[slot], win_high[slot], '0, '0, 1'b0};
            if (record) due_results.push_back(r);
            win_full[slot] = 1'b0;
            next_seq = next_seq + 1'b1;
            walked++;
         end
      end
      r = '{KIND_ACK, '0, '0, '0, p.seq, p.seq, 1'b1};
      if (record) due_results.push_back(r);
   endfunction

   function automatic packet_type random_packet(logic [SEQ_W-1:0] seq, bit good);
      packet_type p;
      p.seq = seq;
      p.ack = SEQ_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 19))
         0: {p.high, p.mid, p.low} = '1;
         1: {p.high, p.mid, p.low} = {PAYLOAD_BYTES{8'h80}};
         2: {p.high, p.mid, p.low} = '0;
         default: begin
            p.low  = {$urandom, $urandom};
            p.mid  = {$urandom, $urandom};
            p.high = $urandom;
         end
      endcase
      p.check = packet_sum(p);
      if (!good) begin
         if ($urandom_range(0, 1) == 1) p.check = p.check ^ (32'd1 << $urandom_range(0, 31));
         else p.check = $urandom;
      end
      return p;
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
   endtask

   task automatic send_packet(packet_type p);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.seq_num      <= p.seq;
      req.ack_num      <= p.ack;
      req.check_value  <= p.check;
      req.payload_low  <= p.low;
      req.payload_mid  <= p.mid;
      req.payload_high <= p.high;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic offer_packet(packet_type p);
      send_packet(p);
      receive_packet(p, 1'b1);
      sent++;
   endtask

   task automatic run_traffic(int count, int req_pct, int rsp_pct, bit wild);
      int unsigned pick;
      int unsigned width;
      int unsigned j;
      int unsigned tmp;
      int unsigned order [SLOTS];
      logic [SEQ_W-1:0] base;
      int stop;
      req_idle_pct  = req_pct;
      rsp_stall_pct = rsp_pct;
      stop = sent + count;
      while (sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            // in-window burst in shuffled order, often closing with the head
            width = ($urandom_range(0, 3) == 0) ? SLOTS : $urandom_range(1, 12);
            if (width > unsigned'(stop - sent)) width = unsigned'(stop - sent);
            base = next_seq;
            for (int i = 0; i < width; i++) order[i] = i;
            for (int i = width - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = order[i];
               order[i] = order[j];
               order[j] = tmp;
            end
            if ($urandom_range(0, 1) == 1) begin
               for (int i = 0; i < width - 1; i++) begin
                  if (order[i] == 0) begin
                     order[i] = order[width-1];
                     order[width-1] = 0;
                  end
               end
            end
            for (int i = 0; i < width; i++) begin
               offer_packet(random_packet(base + SEQ_W'(order[i]), 1'b1));
               case ($urandom_range(0, 9))
                  0: offer_packet(random_packet(base + SEQ_W'(order[i]), 1'b0));
                  1: offer_packet(random_packet(base + SEQ_W'(order[i]), 1'b1));
                  default: ;
               endcase
            end
         end else if (pick < 62) begin
            offer_packet(random_packet(SEQ_W'($urandom_range(0, 65535)), 1'b0));
         end else if (pick < 72 && next_seq > 48) begin
            offer_packet(random_packet(next_seq - SEQ_W'($urandom_range(1, 48)), 1'b1));
         end else if (pick < 82) begin
            if (wild) offer_packet(random_packet(SEQ_W'($urandom_range(0, 65535)), 1'b1));
            else offer_packet(random_packet(next_seq + SEQ_W'($urandom_range(32, 63)), 1'b1));
         end else begin
            offer_packet(random_packet(next_seq + SEQ_W'($urandom_range(0, 7)), 1'b1));
         end
      end
   endtask

   // response side ready, with a long hold-off on request
   initial begin
      int unsigned hold_left;
      int unsigned hold_given;
      hold_left  = 0;
      hold_given = 0;
      rsp.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (hold_given != hold_asked) begin
            hold_given++;
            hold_left = HOLD_CYCLES;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response, kind %0b ack_number %h",
                                      rsp.result_kind, rsp.ack_number));
         end else begin
            want = due_results.pop_front();
            check_field("result_kind", WORD_W'(rsp.result_kind), WORD_W'(want.kind));
            check_field("out_payload_low", rsp.out_payload_low, want.low);
            check_field("out_payload_mid", rsp.out_payload_mid, want.mid);
            check_field("out_payload_high", WORD_W'(rsp.out_payload_high),
                        WORD_W'(want.high));
            check_field("ack_number", WORD_W'(rsp.ack_number), WORD_W'(want.num));
            check_field("ack_check", WORD_W'(rsp.ack_check), WORD_W'(want.chk));
            check_field("last_of_run", WORD_W'(rsp.last_of_run), WORD_W'(want.last));
         end
      end
   end

   initial begin
      #8000000;
      $display("selective_repeat_receiver_unit: mismatch");
      $finish;
   end

   initial begin
      packet_type p;
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.seq_num      = '0;
      req.ack_num      = '0;
      req.check_value  = '0;
      req.payload_low  = '0;
      req.payload_mid  = '0;
      req.payload_high = '0;
      for (int i = 0; i < SLOTS; i++) win_full[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         p = '{dir_rows[i].seq, dir_rows[i].ack, dir_rows[i].check,
               dir_rows[i].low, dir_rows[i].mid, dir_rows[i].high};
         if (dir_rows[i].fix_check) p.check = packet_sum(p);
         send_packet(p);
         if (dir_rows[i].outcome == OUT_PREDICT) begin
            receive_packet(p, 1'b1);
         end else begin
            receive_packet(p, 1'b0);
            if (dir_rows[i].outcome == OUT_SELF_ACK)
               due_results.push_back('{KIND_DELIVER, p.low, p.mid, p.high, '0, '0, 1'b0});
            if (dir_rows[i].outcome != OUT_NONE)
               due_results.push_back('{KIND_ACK, '0, '0, '0, p.seq, p.seq, 1'b1});
         end
      end

      run_traffic(110, 0, 0, 1'b0);
      run_traffic(90, 73, 0, 1'b0);
      run_traffic(90, 0, 73, 1'b0);
      // sender keeps pushing while the response side is held off
      hold_asked++;
      run_traffic(60, 0, 0, 1'b0);
      run_traffic(100, 27, 27, 1'b1);

      req.valid <= 1'b0;
      rsp_stall_pct = 0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("selective_repeat_receiver_unit: match");
      else
         $display("selective_repeat_receiver_unit: mismatch");
      $finish;
   end

endmodule
